### sv/sfl_pkg.sv
`default_nettype none

package sfl_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int MAX_DELAY_W = 14;
    localparam int PHASE_W     = 32;
    localparam int WET_W       = 16;
    localparam int COS_W       = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int MAX_CHANNELS = 2;

    // Q1.15 unity, also the ceiling of the wet gain
    localparam int WET_UNITY = 32768;

    // Register reset values
    localparam logic [MAX_DELAY_W-1:0] MAX_DELAY_RST  = 14'd2400;
    localparam logic [PHASE_W-1:0]     PHASE_STEP_RST = 32'd894785;
    localparam logic [WET_W-1:0]       WET_GAIN_RST   = 16'd0;

    // Parameter defaults
    localparam int DEF_DELAY_DEPTH     = 8192;
    localparam int DEF_COS_TABLE_DEPTH = 1024;
    localparam int DEF_CHANNELS        = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_DELAY  = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_WET_GAIN   = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } result_item_t;

    // Per-step strobes from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic clear;
        logic access;
        logic mult;
    } lane_ctrl_t;

    // sin(pi/2 * x), x and result in Q15, clamped to unity; used for table build
    function automatic logic [COS_W-1:0] quarter_sine(input logic [COS_W-1:0] x);
        longint unsigned xx;
        longint unsigned x2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned s;
        xx    = 64'(x);
        x2    = (xx * xx) >> 15;
        inner = 64'd21077 - ((x2 * 64'd2383) >> 15);
        mid   = 64'd51470 - ((x2 * inner) >> 15);
        s     = (xx * mid) >> 15;
        if (s > 64'(WET_UNITY))
        begin
            s = 64'(WET_UNITY);
        end
        return COS_W'(s);
    endfunction

endpackage

`default_nettype wire

### sv/sfl_lfo.sv
`default_nettype none

module sfl_lfo
    import sfl_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [PHASE_W-1:0]       phase_step,
    input  wire logic                     advance,
    input  wire logic                     lookup,
    output logic signed [COS_W-1:0]       cos_val
);

    localparam int KW = $clog2(COS_TABLE_DEPTH);
    localparam int PW = PHASE_W + KW + 1;

    typedef logic signed [COS_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

    // Full-cycle cosine built by quadrant folding of the quarter sine
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           rom;
        longint unsigned    t;
        logic [1:0]         q;
        logic [COS_W-1:0]   r;
        logic [COS_W-1:0]   s;
        for (int k = 0; k < COS_TABLE_DEPTH; k++)
        begin
            t = ((64'(k) << 16) / COS_TABLE_DEPTH) & 64'hFFFF;
            q = t[15:14];
            r = COS_W'(t[13:0]);
            unique case (q)
                2'd0:    s = quarter_sine((17'd16384 - r) << 1);
                2'd1:    s = quarter_sine(r << 1);
                2'd2:    s = quarter_sine((17'd16384 - r) << 1);
                default: s = quarter_sine(r << 1);
            endcase
            if (q == 2'd1 || q == 2'd2)
            begin
                rom[k] = -signed'(s);
            end
            else
            begin
                rom[k] = signed'(s);
            end
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    logic [PHASE_W-1:0]       phase_reg;
    logic [KW-1:0]            k_reg;
    logic signed [COS_W-1:0]  cos_reg;
    logic [PW-1:0]            k_prod;

    assign k_prod = PW'(phase_reg) * PW'(COS_TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_reg + phase_step;
        end
    end

    // Table index taken from the phase before it advances
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            k_reg <= k_prod[PHASE_W +: KW];
        end
        if (lookup)
        begin
            cos_reg <= COS_ROM[k_reg];
        end
    end

    assign cos_val = cos_reg;

endmodule

`default_nettype wire

### sv/sfl_lane.sv
`default_nettype none

module sfl_lane
    import sfl_pkg::*;
#(
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH
)
(
    input  wire logic                        clk,
    input  wire lane_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0]  x,
    input  wire logic [WET_W-1:0]            wet,
    input  wire logic [$clog2(DELAY_DEPTH)-1:0] wr_addr,
    input  wire logic [$clog2(DELAY_DEPTH)-1:0] rd_addr,
    output logic signed [SAMPLE_W-1:0]       y
);

    logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       hit_reg;
    logic signed [33:0]         prod_reg;

    logic signed [SAMPLE_W-1:0] dl;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [WET_W:0]      wet_s;
    logic signed [34:0]         sum;
    logic signed [18:0]         yw;

    // Delay line: one write and one registered read per cycle, on the access strobe; zeros are written on clear
    always_ff @(posedge clk)
    begin
        if (ctrl.clear || ctrl.access)
        begin
            mem[wr_addr] <= ctrl.clear ? '0 : x_reg;
        end
        if (ctrl.access)
        begin
            rd_data_reg <= mem[rd_addr];
            hit_reg     <= (rd_addr == wr_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= x;
        end
        if (ctrl.mult)
        begin
            prod_reg <= 34'(diff) * 34'(wet_s);
        end
    end

    // Full-length delay reads the sample written in the same step
    assign dl    = hit_reg ? x_reg : rd_data_reg;
    assign diff  = (SAMPLE_W+1)'(dl) - (SAMPLE_W+1)'(x_reg);
    assign wet_s = signed'({1'b0, wet});

    assign sum = (35'(x_reg) <<< 16) + 35'(prod_reg) + 35'(WET_UNITY);
    assign yw  = 19'(sum >>> 16);

    always_comb
    begin
        if (yw > 19'sd32767)
        begin
            y = 16'sh7FFF;
        end
        else if (yw < -19'sd32768)
        begin
            y = 16'sh8000;
        end
        else
        begin
            y = yw[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/stereo_flanger_unit.sv
`default_nettype none

// Stereo flanger. Each accepted item is one stereo frame; each channel runs in a
// lane of its own with a private delay line of DELAY_DEPTH samples, and both lanes
// share one cosine oscillator and one delay computation. An item passes through the
// block in steps: it is taken and the table index fetched, the cosine table is read,
// the delay is multiplied, the delay line is written and read, the wet gain is
// multiplied, and the result is rounded, saturated and handed to the output
// register. A new item may be taken while the previous result still waits there;
// only if that result is still unread when the next one is ready does the block hold.
// After reset the delay lines are swept to zero, one address a cycle, and no item is
// taken until the sweep ends. A write to max_delay while idle folds the write position
// into the new length with a bit-serial remainder, during which items and further
// configuration writes are held off. Otherwise cfg_ready is high, except in a
// cycle in which an item is taken; write max_delay, phase_step or wet_gain only
// while no item is in flight.
module stereo_flanger_unit
    import sfl_pkg::*;
#(
    parameter int DELAY_DEPTH     = DEF_DELAY_DEPTH,
    parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH,
    parameter int CHANNELS        = DEF_CHANNELS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire sample_item_t           sample,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output result_item_t                result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int LW = $clog2(DELAY_DEPTH + 1);
    localparam int SW = $clog2(AW + 1);
    localparam int DW = LW + COS_W;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_REDUCE = 8'b0000_0010,
        ST_IDLE   = 8'b0000_0100,
        ST_LFO    = 8'b0000_1000,
        ST_DELAY  = 8'b0001_0000,
        ST_ACCESS = 8'b0010_0000,
        ST_MIX    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [MAX_DELAY_W-1:0]   max_delay_reg, max_delay_next;
    logic [PHASE_W-1:0]       phase_step_reg, phase_step_next;
    logic [WET_W-1:0]         wet_gain_reg, wet_gain_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic [AW-1:0]            shift_reg, shift_next;
    logic [SW-1:0]            steps_reg, steps_next;
    logic [LW-1:0]            d_reg, d_next;
    logic                     result_valid_reg, result_valid_next;
    result_item_t             result_reg, result_next;

    logic                     accept;
    logic                     cfg_write;
    logic                     out_load;
    logic [LW-1:0]            len;
    logic [WET_W-1:0]         wet;
    logic signed [COS_W-1:0]  cos_val;
    logic signed [COS_W:0]    cos_sum;
    logic [COS_W-1:0]         cos_off;
    logic [DW-1:0]            d_prod;
    logic [LW:0]              d_raw;
    logic [LW:0]              rd_sum;
    logic [LW:0]              rd_wrap;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [LW:0]              pos_inc;
    logic [AW:0]              trial;
    logic [AW:0]              len_x;
    lane_ctrl_t               lane_ctrl;

    logic signed [SAMPLE_W-1:0] lane_x [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] lane_y [MAX_CHANNELS];

    // Handshakes; hold configuration off during the fold and while an item is taken
    assign accept       = sample_valid && sample_ready;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign cfg_ready    = (state_reg != ST_REDUCE) && !accept;
    assign out_load     = (state_reg == ST_OUT) && (!result_valid_reg || result_ready);

    // Length in use: zero acts as one, clamp to the physical depth
    always_comb
    begin
        if (max_delay_reg == '0)
        begin
            len = LW'(1);
        end
        else if (32'(max_delay_reg) > 32'(DELAY_DEPTH))
        begin
            len = LW'(DELAY_DEPTH);
        end
        else
        begin
            len = LW'(max_delay_reg);
        end
    end

    assign wet = (32'(wet_gain_reg) > 32'(WET_UNITY)) ? WET_W'(WET_UNITY) : wet_gain_reg;

    // Delay d = (len * (1 + cos)) >> 16, never beyond len
    assign cos_sum = (COS_W+1)'(cos_val) + (COS_W+1)'(WET_UNITY);
    assign cos_off = cos_sum[COS_W-1:0];
    assign d_prod  = DW'(len) * DW'(cos_off);
    assign d_raw   = d_prod[DW-1:16];
    assign d_next  = (d_raw > (LW+1)'(len)) ? len : d_raw[LW-1:0];

    // Read index: pos + len - d, folded once into the buffer
    assign rd_sum  = (LW+1)'(pos_reg) + (LW+1)'(len) - (LW+1)'(d_reg);
    assign rd_wrap = (rd_sum >= (LW+1)'(len)) ? rd_sum - (LW+1)'(len) : rd_sum;
    assign rd_addr = rd_wrap[AW-1:0];
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : pos_reg;

    assign pos_inc = (LW+1)'(pos_reg) + (LW+1)'(1);

    // One remainder bit per cycle when the length changes
    assign len_x = (AW+1)'(len);
    assign trial = {pos_reg, shift_reg[AW-1]};

    // Configuration registers
    always_comb
    begin
        max_delay_next  = max_delay_reg;
        phase_step_next = phase_step_reg;
        wet_gain_next   = wet_gain_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_MAX_DELAY:  max_delay_next  = cfg_data[MAX_DELAY_W-1:0];
                CFG_PHASE_STEP: phase_step_next = cfg_data[PHASE_W-1:0];
                CFG_WET_GAIN:   wet_gain_next   = cfg_data[WET_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        clr_addr_next = clr_addr_reg;
        shift_next    = shift_reg;
        steps_next    = steps_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DELAY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE:
            begin
                pos_next   = (trial >= len_x) ? AW'(trial - len_x) : AW'(trial);
                shift_next = shift_reg << 1;
                steps_next = steps_reg - 1'b1;
                if (steps_reg == SW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                priority if (accept)
                begin
                    state_next = ST_LFO;
                end
                else if (cfg_write && cfg_reg_e'(cfg_index) == CFG_MAX_DELAY)
                begin
                    state_next = ST_REDUCE;
                    shift_next = pos_reg;
                    pos_next   = '0;
                    steps_next = SW'(AW);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LFO:    state_next = ST_DELAY;
            ST_DELAY:  state_next = ST_ACCESS;
            ST_ACCESS: state_next = ST_MIX;
            ST_MIX:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                    pos_next   = (pos_inc == (LW+1)'(len)) ? '0 : pos_inc[AW-1:0];
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Output register: merge the lanes and hold until taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (out_load)
        begin
            result_valid_next      = 1'b1;
            result_next.out_left   = lane_y[0];
            result_next.out_right  = lane_y[1];
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            max_delay_reg    <= MAX_DELAY_RST;
            phase_step_reg   <= PHASE_STEP_RST;
            wet_gain_reg     <= WET_GAIN_RST;
            pos_reg          <= '0;
            clr_addr_reg     <= '0;
            steps_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            max_delay_reg    <= max_delay_next;
            phase_step_reg   <= phase_step_next;
            wet_gain_reg     <= wet_gain_next;
            pos_reg          <= pos_next;
            clr_addr_reg     <= clr_addr_next;
            steps_reg        <= steps_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        result_reg <= result_next;
        if (state_reg == ST_DELAY)
        begin
            d_reg <= d_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Shared oscillator: advance once per frame
    sfl_lfo #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_lfo (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_step (phase_step_reg),
        .advance    (accept),
        .lookup     (state_reg == ST_LFO),
        .cos_val    (cos_val)
    );

    assign lane_ctrl.load   = accept;
    assign lane_ctrl.clear  = (state_reg == ST_CLEAR);
    assign lane_ctrl.access = (state_reg == ST_ACCESS);
    assign lane_ctrl.mult   = (state_reg == ST_MIX);

    assign lane_x[0] = sample.sample_left;
    assign lane_x[1] = sample.sample_right;

    // One lane per channel; a missing channel reads as silence
    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_lane
        if (g < CHANNELS)
        begin : g_on
            sfl_lane #(
                .DELAY_DEPTH (DELAY_DEPTH)
            ) u_lane (
                .clk     (clk),
                .ctrl    (lane_ctrl),
                .x       (lane_x[g]),
                .wet     (wet),
                .wr_addr (wr_addr),
                .rd_addr (rd_addr),
                .y       (lane_y[g])
            );
        end
        else
        begin : g_off
            assign lane_y[g] = '0;
        end
    end

    // An accepted item reaches the output step through the lfo, delay, access and mix states
    a_item_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 (state_reg == ST_OUT))
        else $error("item did not reach the output step on time");

    // A new result appears only from the output step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output step");

    // The clearing sweep steps one address a cycle and ends at the last address
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=>
            ((state_reg == ST_CLEAR && clr_addr_reg == AW'($past(clr_addr_reg) + 1'b1))
            || (state_reg == ST_IDLE && $past(clr_addr_reg) == AW'(DELAY_DEPTH - 1))))
        else $error("clearing sweep out of step");

endmodule

`default_nettype wire
